// ===== hw/rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Shared constants and the pitch code to rate lookup for the sample header
// scanner.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned NumRates = 12;

  localparam logic [31:0] LoopFlag      = 32'h4000_0000;
  localparam logic [31:0] NoFlags       = 32'h0000_0000;
  // bounds on the raw length word (length minus one)
  localparam logic [31:0] MinRawLength  = 32'd3;
  localparam logic [31:0] MaxRawLength  = 32'd3_999_999;

  localparam int unsigned ImageSizeW    = 26;
  localparam int unsigned RateW         = 16;
  localparam int unsigned LengthW       = 22;
  localparam int unsigned SkipW         = 20;
  localparam logic [ImageSizeW-1:0] ImageSizeRst = 26'h200_0000;

  localparam logic [31:0] PitchCodes [NumRates] = '{
    32'h0059_9800, 32'h007b_3000, 32'h00a4_4000, 32'h00d1_0c00,
    32'h00f6_6000, 32'h011b_b400, 32'h0148_8000, 32'h01a2_1800,
    32'h01ec_c000, 32'h0237_6800, 32'h0273_2400, 32'h0291_0000
  };

  localparam logic [RateW-1:0] RateTable [NumRates] = '{
    16'd5734,  16'd7884,  16'd10512, 16'd13379,
    16'd15768, 16'd18157, 16'd21024, 16'd26758,
    16'd31536, 16'd36314, 16'd40137, 16'd42048
  };

  typedef struct packed {
    logic             hit;
    logic [RateW-1:0] hz;
  } rate_lookup_t;

  // twelve parallel compares, at most one can match
  function automatic rate_lookup_t lookup_rate(input logic [31:0] code);
    rate_lookup_t res;
    res.hit = 1'b0;
    res.hz  = '0;
    for (int k = 0; k < NumRates; k++) begin
      if (PitchCodes[k] == code) begin
        res.hit = 1'b1;
        res.hz  = RateTable[k];
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sample_header_scanner.sv =====
// ----------------------------------------------------------------------------
// sample_header_scanner
// Streams an image one 32-bit word per beat, tests each word-aligned window
// of four words as a sample header and reports each match, then skips the
// sample body.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                         handshake
//  --------  ---------  ------------------------------  ---------------
//  in        input      rom_word_i                      in_valid_i/in_ready_o
//  out       output     header_offset_o, rate_hz_o,     out_valid_o/out_ready_i
//                       sample_length_o, loop_begin_o,
//                       is_looped_o
//  cfg       input      cfg_wdata_i (image size bytes)  cfg_we_i, no wait
//
//  One word per cycle while the input is not stalled. A word is checked against
//  the three held words in the cycle it is accepted and a hit is registered on
//  that edge, in the output register or, if that is full and not taken, the skid.
//  A two-entry output buffer (output register plus skid) keeps the input
//  open while one result waits; the input stalls only when both are full.
//  Reset clears the window, skip count, word address and output valids and
//  sets the image size to 32 MiB.
//
module sample_header_scanner #(
  parameter int unsigned ADDR_BITS = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [shs_pkg::ImageSizeW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [31:0]                       rom_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ADDR_BITS-1:0]              header_offset_o,
  output logic [shs_pkg::RateW-1:0]         rate_hz_o,
  output logic [shs_pkg::LengthW-1:0]       sample_length_o,
  output logic [shs_pkg::LengthW-1:0]       loop_begin_o,
  output logic                              is_looped_o
);
  import shs_pkg::*;

  localparam int unsigned WordAddrW = ADDR_BITS - 2;
  localparam int unsigned SumW = ((ADDR_BITS > ImageSizeW) ? ADDR_BITS : ImageSizeW) + 1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] offset;
    logic [RateW-1:0]     hz;
    logic [LengthW-1:0]   length;
    logic [LengthW-1:0]   loop_begin;
    logic                 looped;
  } result_t;

  logic [ImageSizeW-1:0] image_size_q;
  logic [31:0]           win_q [3];
  logic [1:0]            fill_q;
  logic [SkipW-1:0]      skip_q;
  logic [WordAddrW-1:0]  addr_q;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic                  in_fire, out_fire, push;
  logic                  looped, flags_ok, len_ok, loop_ok, size_ok, hit;
  rate_lookup_t          rate;
  logic [WordAddrW-1:0]  start_word;
  logic [ADDR_BITS-1:0]  start_byte;
  logic [LengthW-1:0]    length;
  logic [SumW-1:0]       end_byte;
  result_t               res;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // header check on the three held words plus the arriving one
  always_comb begin
    looped     = (win_q[0] == LoopFlag);
    flags_ok   = looped || (win_q[0] == NoFlags);
    rate       = lookup_rate(win_q[1]);
    len_ok     = (rom_word_i >= MinRawLength) && (rom_word_i <= MaxRawLength);
    // loop start + 1 > length + 1, no wrap in 33 bits
    loop_ok    = !(looped && (win_q[2] > rom_word_i));
    length     = rom_word_i[LengthW-1:0] + LengthW'(1);
    start_word = addr_q - WordAddrW'(3);
    start_byte = {start_word, 2'b00};
    end_byte   = SumW'(start_byte) + SumW'(length) + SumW'(16);
    size_ok    = end_byte <= SumW'(image_size_q);
    hit        = (skip_q == '0) && (fill_q == 2'd3) && flags_ok && rate.hit
                 && len_ok && loop_ok && size_ok;

    res.offset     = start_byte;
    res.hz         = rate.hz;
    res.length     = length;
    res.loop_begin = looped ? (win_q[2][LengthW-1:0] + LengthW'(1)) : '0;
    res.looped     = looped;
  end

  assign push = in_fire && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= ImageSizeRst;
      fill_q       <= '0;
      skip_q       <= '0;
      addr_q       <= '0;
      win_q[0]     <= '0;
      win_q[1]     <= '0;
      win_q[2]     <= '0;
    end else begin
      if (cfg_we_i) begin
        image_size_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        addr_q <= addr_q + WordAddrW'(1);
        if (skip_q != '0) begin
          skip_q <= skip_q - SkipW'(1);
        end else if (fill_q != 2'd3) begin
          win_q[fill_q] <= rom_word_i;
          fill_q        <= fill_q + 2'd1;
        end else if (hit) begin
          fill_q <= '0;
          // body rounded up to whole words
          skip_q <= rom_word_i[LengthW-1:2] + SkipW'(1);
        end else begin
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= rom_word_i;
        end
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_q && !out_ready_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign header_offset_o = out_q.offset;
  assign rate_hz_o       = out_q.hz;
  assign sample_length_o = out_q.length;
  assign loop_begin_o    = out_q.loop_begin;
  assign is_looped_o     = out_q.looped;

endmodule

// ===== hw/rtl/shs_checker.sv =====
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks on the sample header scanner, bound to the top level.
// ----------------------------------------------------------------------------
module shs_checker #(
  parameter int unsigned ADDR_BITS = 25
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [shs_pkg::ImageSizeW-1:0] cfg_wdata_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [31:0]                    rom_word_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ADDR_BITS-1:0]           header_offset_o,
  input logic [shs_pkg::RateW-1:0]      rate_hz_o,
  input logic [shs_pkg::LengthW-1:0]    sample_length_o,
  input logic [shs_pkg::LengthW-1:0]    loop_begin_o,
  input logic                           is_looped_o
);
  import shs_pkg::*;

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_length_o >= LengthW'(4)) &&
                    (sample_length_o <= LengthW'(4_000_000)))
    else $error("sample length out of range");

  a_loop_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_looped_o |->
      (loop_begin_o != '0) && (loop_begin_o <= sample_length_o))
    else $error("loop start outside sample");

  a_no_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_looped_o |-> loop_begin_o == '0)
    else $error("loop start set on unlooped sample");

  // a full output side stalls the input until the sink takes a beat
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("input stayed stalled after output beat");

endmodule

bind sample_header_scanner shs_checker #(.ADDR_BITS(ADDR_BITS)) u_shs_checker (.*);

// ===== tb/sv/sample_header_checker.sv =====
// ----------------------------------------------------------------------------
// sample_header_checker
// Watches the word, result and image-size ports of the sample header scanner,
// keeps its own copy of the scan window, skip count, word address and image
// size, predicts every header hit and compares each result beat field by
// field against the oldest predicted header.
// ----------------------------------------------------------------------------
module sample_header_checker #(
  parameter int unsigned ADDR_BITS = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [shs_pkg::ImageSizeW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [31:0]                    rom_word_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [ADDR_BITS-1:0]           header_offset_i,
  input  logic [shs_pkg::RateW-1:0]      rate_hz_i,
  input  logic [shs_pkg::LengthW-1:0]    sample_length_i,
  input  logic [shs_pkg::LengthW-1:0]    loop_begin_i,
  input  logic                           is_looped_i,
  output int unsigned                    fail_cnt_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import shs_pkg::*;

  localparam int unsigned WordAddrW = ADDR_BITS - 2;
  localparam logic [63:0] MinLen    = 64'd4;
  localparam logic [63:0] MaxLen    = 64'd4_000_000;
  localparam int unsigned MaxShown  = 10;

  typedef struct {
    logic [ADDR_BITS-1:0] offset;
    logic [RateW-1:0]     hz;
    logic [LengthW-1:0]   length;
    logic [LengthW-1:0]   loop_start;
    logic                 looped;
  } sample_hdr_t;

  sample_hdr_t           found_headers[$];
  logic [31:0]           held_words[3];
  int unsigned           held_cnt;
  logic [SkipW-1:0]      body_left;
  logic [WordAddrW-1:0]  word_addr;
  logic [ImageSizeW-1:0] image_bytes;

  function automatic bit rate_of(input logic [31:0] code, output logic [RateW-1:0] hz);
    hz = '0;
    for (int k = 0; k < NumRates; k++) begin
      if (PitchCodes[k] == code) begin
        hz = RateTable[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_failure(input string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= MaxShown) $display("%0t: %s", $realtime, msg);
  endtask

  // one word beat through the scan window
  task automatic scan_word(input logic [31:0] w);
    logic [WordAddrW-1:0] here;
    logic [WordAddrW-1:0] first;
    logic [63:0]          len;
    logic [63:0]          lstart;
    logic [63:0]          first_byte;
    logic [RateW-1:0]     hz;
    bit                   looped;
    bit                   hit;
    bit                   ok;
    sample_hdr_t          hdr;
    here      = word_addr;
    word_addr = here + 1'b1;
    if (body_left != 0) begin
      body_left = body_left - 1'b1;
      return;
    end
    if (held_cnt < 3) begin
      held_words[held_cnt] = w;
      held_cnt++;
      return;
    end
    len        = {32'd0, w} + 64'd1;
    lstart     = {32'd0, held_words[2]} + 64'd1;
    looped     = (held_words[0] == LoopFlag);
    first      = here - WordAddrW'(3);
    first_byte = 64'(first) << 2;
    hit        = rate_of(held_words[1], hz);
    ok = (held_words[0] == NoFlags) || looped;
    ok = ok && hit && len >= MinLen && len <= MaxLen;
    ok = ok && !(looped && lstart > len);
    ok = ok && (first_byte + 64'd16 + len <= 64'(image_bytes));
    if (!ok) begin
      held_words[0] = held_words[1];
      held_words[1] = held_words[2];
      held_words[2] = w;
      return;
    end
    hdr.offset     = first_byte[ADDR_BITS-1:0];
    hdr.hz         = hz;
    hdr.length     = len[LengthW-1:0];
    hdr.loop_start = looped ? lstart[LengthW-1:0] : '0;
    hdr.looped     = looped;
    found_headers = {found_headers, hdr};
    held_cnt  = 0;
    body_left = SkipW'((len + 64'd3) >> 2);
  endtask

  task automatic check_result();
    sample_hdr_t want;
    if (found_headers.size() == 0) begin
      report_failure($sformatf("unexpected result off=%0h rate=%0d len=%0d",
                               header_offset_i, rate_hz_i, sample_length_i));
      return;
    end
    want = found_headers.pop_front();
    if (header_offset_i !== want.offset || rate_hz_i !== want.hz ||
        sample_length_i !== want.length || loop_begin_i !== want.loop_start ||
        is_looped_i !== want.looped) begin
      report_failure($sformatf({"header mismatch exp off=%0h rate=%0d len=%0d loop=%0d ",
                                "looped=%0b got off=%0h rate=%0d len=%0d loop=%0d looped=%0b"},
                               want.offset, want.hz, want.length, want.loop_start,
                               want.looped, header_offset_i, rate_hz_i, sample_length_i,
                               loop_begin_i, is_looped_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_headers.delete();
      held_words  = '{default: '0};
      held_cnt    = 0;
      body_left   = '0;
      word_addr   = '0;
      image_bytes = ImageSizeRst;
      fail_cnt_o  = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) image_bytes = cfg_wdata_i;
      if (in_valid_i && in_ready_i) scan_word(rom_word_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o = found_headers.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams image words into the sample header scanner: directed headers at the
// field limits and image-size bounds, one maximum-length sample, random
// phases of well-formed headers with bodies mixed with broken headers and
// noise under varying sender and receiver idling, and a long receiver hold-off
// that backs the block up. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import shs_pkg::*;

  localparam int unsigned AddrBits          = 25;
  localparam int unsigned WatchdogLimit     = 4000;
  localparam int unsigned ScanWordsPerPhase = 70;
  localparam int unsigned NumPhases         = 8;
  localparam int unsigned HoldOffCycles     = 300;
  localparam int unsigned SettleCycles      = 4;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [ImageSizeW-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [31:0]           rom_word_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [AddrBits-1:0]   header_offset_o;
  logic [RateW-1:0]      rate_hz_o;
  logic [LengthW-1:0]    sample_length_o;
  logic [LengthW-1:0]    loop_begin_o;
  logic                  is_looped_o;

  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  int unsigned words_sent    = 0;
  int unsigned scanned_words = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned fail_cnt;
  int unsigned pending;

  sample_header_scanner #(.ADDR_BITS(AddrBits)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .rom_word_i,
    .out_valid_o, .out_ready_i,
    .header_offset_o, .rate_hz_o, .sample_length_o, .loop_begin_o, .is_looped_o
  );

  sample_header_checker #(.ADDR_BITS(AddrBits)) hdr_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .rom_word_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .header_offset_i(header_offset_o), .rate_hz_i(rate_hz_o),
    .sample_length_i(sample_length_o), .loop_begin_i(loop_begin_o),
    .is_looped_i(is_looped_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // result side: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // body words are skipped by the block and do not count as scanned
  task automatic send_word(input logic [31:0] w, input bit scanned);
    bit rdy;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rom_word_i <= w;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    words_sent++;
    if (scanned) scanned_words++;
  endtask

  task automatic send_header(input logic [31:0] flags, input logic [31:0] code,
                             input logic [31:0] loop_raw, input logic [31:0] len_raw,
                             input bit with_body);
    longint unsigned body_words;
    body_words = (longint'(len_raw) + 4) >> 2;
    send_word(flags, 1'b1);
    send_word(code, 1'b1);
    send_word(loop_raw, 1'b1);
    send_word(len_raw, 1'b1);
    if (with_body) repeat (body_words) send_word($urandom, 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_image_size(input logic [ImageSizeW-1:0] bytes);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bytes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned           pick;
    int unsigned           start_cnt;
    int unsigned           n;
    logic [31:0]           flags;
    logic [31:0]           code;
    logic [31:0]           lraw;
    logic [31:0]           loop_raw;
    logic [ImageSizeW-1:0] bound;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // header right at offset 0, then one straight after its body
    send_header(NoFlags, PitchCodes[0], 32'hFFFF_FFFF, MinRawLength, 1'b1);
    send_header(LoopFlag, PitchCodes[NumRates-1], 32'd7, 32'd7, 1'b1);
    for (int k = 0; k < NumRates; k++)
      send_header((k % 2) ? LoopFlag : NoFlags, PitchCodes[k], 32'd0, MinRawLength, 1'b1);

    // headers that must be rejected
    send_header(NoFlags, PitchCodes[2], 32'd0, 32'd2, 1'b0);
    send_header(NoFlags, PitchCodes[2], 32'd0, MaxRawLength + 1, 1'b0);
    send_header(LoopFlag, PitchCodes[4], 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_header(32'd1, PitchCodes[1], 32'd0, 32'd10, 1'b0);
    send_header(LoopFlag | 32'd1, PitchCodes[1], 32'd0, 32'd10, 1'b0);
    send_header(NoFlags, PitchCodes[3] + 1, 32'd0, 32'd10, 1'b0);
    send_header(LoopFlag, PitchCodes[8], 32'd11, 32'd10, 1'b0);
    send_header(LoopFlag, PitchCodes[9], 32'hFFFF_FFFF, 32'd10, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'd0, 1'b1);
    drain();

    // image size bound: exact fit, one byte short, empty image
    bound = ImageSizeW'(words_sent * 4 + 16 + 40);
    write_image_size(bound);
    send_header(NoFlags, PitchCodes[5], 32'd0, 32'd39, 1'b1);
    drain();
    bound = ImageSizeW'(words_sent * 4 + 16 + 40 - 1);
    write_image_size(bound);
    send_header(NoFlags, PitchCodes[5], 32'd0, 32'd39, 1'b0);
    drain();
    write_image_size('0);
    send_header(NoFlags, PitchCodes[6], 32'd0, MinRawLength, 1'b0);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p % 2 == 0) write_image_size(ImageSizeRst);
      else write_image_size(ImageSizeW'(words_sent * 4 + $urandom_range(3000)));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      start_cnt = scanned_words;
      while (scanned_words - start_cnt < ScanWordsPerPhase) begin
        pick     = $urandom_range(99);
        flags    = $urandom_range(1) ? LoopFlag : NoFlags;
        code     = PitchCodes[$urandom_range(NumRates-1)];
        lraw     = ($urandom_range(19) == 0) ? $urandom_range(400, 3) : $urandom_range(60, 3);
        loop_raw = (flags == LoopFlag) ? $urandom_range(lraw, 0) : $urandom;
        if (pick < 70) begin
          send_header(flags, code, loop_raw, lraw, 1'b1);
        end else if (pick < 85) begin
          case ($urandom_range(4))
            0: flags = LoopFlag ^ (32'd1 << $urandom_range(31));
            1: code = code ^ (32'd1 << $urandom_range(31));
            2: lraw = $urandom_range(1) ? $urandom_range(2)
                                        : $urandom_range(32'hFFFF_FFFF, MaxRawLength + 1);
            3: begin
              flags    = LoopFlag;
              loop_raw = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                                  : lraw + 1 + $urandom_range(100);
            end
            default: flags = $urandom;
          endcase
          send_header(flags, code, loop_raw, lraw, 1'b0);
        end else begin
          n = $urandom_range(6, 1);
          repeat (n) send_word($urandom, 1'b1);
        end
      end
    end

    // receiver holds off while short samples keep coming, so the input backs up
    drain();
    write_image_size(ImageSizeRst);
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = HoldOffCycles;
    repeat (20) begin
      send_header($urandom_range(1) ? LoopFlag : NoFlags,
                  PitchCodes[$urandom_range(NumRates-1)], 32'd0, MinRawLength, 1'b1);
    end
    drain();

    // longest sample, looped at its last byte; the run ends inside its body
    send_header(LoopFlag, PitchCodes[10], MaxRawLength, MaxRawLength, 1'b0);
    drain();
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sample_header_scanner.f =====
hw/rtl/shs_pkg.sv
hw/rtl/sample_header_scanner.sv
hw/rtl/shs_checker.sv
tb/sv/sample_header_checker.sv
tb/sv/testbench.sv
